// ===== hw/rtl/kwdt_pkg.sv =====
// Shared types and constants for the keyed watchdog timer.
// Used by kwdt_core, keyed_watchdog_timer_unit and tb_top; no dependencies.
package kwdt_pkg;

  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 8;
  localparam int COUNT_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam logic [ADDR_W-1:0] OFS_CTRL   = 8'h00;
  localparam logic [ADDR_W-1:0] OFS_RELOAD = 8'h04;
  localparam logic [ADDR_W-1:0] OFS_COUNT  = 8'h08;
  localparam logic [ADDR_W-1:0] OFS_STATUS = 8'h0c;
  localparam logic [ADDR_W-1:0] OFS_KEY    = 8'h10;

  localparam logic [DATA_W-1:0] KEY_FEED = 32'h5a5a_5a5a;
  localparam logic [DATA_W-1:0] KEY_LOCK = 32'h1acc_e551;

  // control register bit positions
  localparam int CTL_EN    = 0;
  localparam int CTL_IRQEN = 1;
  localparam int CTL_RSTEN = 2;
  localparam int CTL_LOCK  = 3;
  localparam int CTL_W     = 4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bad_offset;
    logic              irq_level;
    logic              reset_pulse;
    logic              timeout_status;
  } result_t;

endpackage

// ===== hw/rtl/kwdt_core.sv =====
// Watchdog register file, counter and per-item result logic.
// Depends on kwdt_pkg; instantiated by keyed_watchdog_timer_unit.
module kwdt_core
  import kwdt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [CTL_W-1:0]      ctrl_r,    ctrl_nxt;
  logic [COUNT_BITS-1:0] reload_r,  reload_nxt;
  logic [COUNT_BITS-1:0] count_r,   count_nxt;
  logic                  timeout_r, timeout_nxt;
  logic                  armed_r,   armed_nxt;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    timeout_nxt = timeout_r;
    armed_nxt   = armed_r;
    res         = '0;

    case (op_t'(item.opcode))
      OP_TICK: begin
        if (armed_r && ctrl_r[CTL_EN]) begin
          if (count_r > COUNT_BITS'(1)) begin
            count_nxt = count_r - COUNT_BITS'(1);
          end else begin
            // expire: fire once and disarm
            count_nxt       = '0;
            timeout_nxt     = 1'b1;
            armed_nxt       = 1'b0;
            res.reset_pulse = ctrl_r[CTL_RSTEN];
          end
        end
      end
      OP_READ: begin
        case (item.address)
          OFS_CTRL:   res.read_data = DATA_W'(ctrl_r);
          OFS_RELOAD: res.read_data = DATA_W'(reload_r);
          OFS_COUNT:  res.read_data = DATA_W'(count_r);
          OFS_STATUS: res.read_data = DATA_W'(timeout_r);
          OFS_KEY:    res.read_data = '0;
          default:    res.bad_offset = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (item.address)
          OFS_CTRL: begin
            if (!ctrl_r[CTL_LOCK]) begin
              ctrl_nxt = {ctrl_r[CTL_LOCK], item.write_data[CTL_RSTEN:CTL_EN]};
              if (item.write_data[CTL_EN] != ctrl_r[CTL_EN]) begin
                armed_nxt = item.write_data[CTL_EN];
                if (item.write_data[CTL_EN]) begin
                  count_nxt = reload_r;
                end
              end
            end
          end
          OFS_RELOAD: reload_nxt = item.write_data[COUNT_BITS-1:0];
          OFS_STATUS: timeout_nxt = timeout_r & ~item.write_data[0];
          OFS_KEY: begin
            if (item.write_data == KEY_FEED) begin
              count_nxt = reload_r;
              armed_nxt = ctrl_r[CTL_EN];
            end else if (item.write_data == KEY_LOCK) begin
              ctrl_nxt[CTL_LOCK] = 1'b1;
            end
          end
          default: res.bad_offset = 1'b1;
        endcase
      end
      default: ;
    endcase

    res.timeout_status = timeout_nxt;
    res.irq_level      = timeout_nxt & ctrl_nxt[CTL_IRQEN];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      reload_r  <= '0;
      count_r   <= '0;
      timeout_r <= 1'b0;
      armed_r   <= 1'b0;
    end else if (fire) begin
      ctrl_r    <= ctrl_nxt;
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      timeout_r <= timeout_nxt;
      armed_r   <= armed_nxt;
    end
  end

endmodule

// ===== hw/rtl/keyed_watchdog_timer_unit.sv =====
// Keyed watchdog timer top level: input register, core, result register.
// Depends on kwdt_pkg and kwdt_core.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | opcode, address, write_data
//   out_    | output    | out_valid/out_stall | read_data, bad_offset, irq_level,
//           |           |                   | reset_pulse, timeout_status
//
// One item per cycle sustained while out_stall stays low; out_valid rises after
// the in transfer once the item has passed the input register, then core logic
// into the result register, unless a held result blocks the advance.
// Synchronous rst_n reset zeroes valid flags and core state; counter disarmed.
// out_stall holds the result register; the input register then holds too, and
// in_stall rises only once both registers are full.
module keyed_watchdog_timer_unit
  import kwdt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_bad_offset,
  output logic              out_irq_level,
  output logic              out_reset_pulse,
  output logic              out_timeout_status
);

  logic    stg_vld_r;
  item_t   stg_item_r;
  logic    out_vld_r;
  result_t res_r;
  result_t core_res;
  logic    adv;
  logic    in_xfer;

  assign adv      = stg_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stg_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_xfer) begin
      stg_vld_r <= 1'b1;
    end else if (adv) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_item_r <= '{opcode: in_opcode, address: in_address, write_data: in_write_data};
    end
  end

  kwdt_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (adv),
    .item (stg_item_r),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_read_data      = res_r.read_data;
  assign out_bad_offset     = res_r.bad_offset;
  assign out_irq_level      = res_r.irq_level;
  assign out_reset_pulse    = res_r.reset_pulse;
  assign out_timeout_status = res_r.timeout_status;

  a_pulse_sets_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.reset_pulse |-> res_r.timeout_status)
    else $error("reset pulse without timeout status");

  a_irq_needs_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.irq_level |-> res_r.timeout_status)
    else $error("interrupt level without timeout status");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !adv |=> stg_vld_r && $stable(stg_item_r))
    else $error("input register lost a held item");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stg_vld_r)
    else $error("accepted item not captured");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for keyed_watchdog_timer_unit: directed rows, random watchdog
// sessions, lock rows, more sessions; checked against a cycle-free register-file predictor.
// Depends on kwdt_pkg and the RTL of keyed_watchdog_timer_unit.
module tb_top
  import kwdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        OP_NOP      = 2'd3;
  localparam logic [DATA_W-1:0] CNT_MASK    = 32'hffff_ffff >> (DATA_W - COUNT_BITS_DEF);
  localparam int                PAUSE_AT    = 550;
  localparam int                RANDOM_END  = 1020;
  localparam int                ITEM_TOTAL  = 1100;
  localparam int                HOLD_FIRST  = 200;
  localparam int                HOLD_SECOND = 800;
  localparam int                LONG_HOLD   = 80;
  localparam int                CYCLE_LIMIT = 600000;

  localparam logic [ADDR_W-1:0] REG_OFS [5] = '{OFS_CTRL, OFS_RELOAD, OFS_COUNT, OFS_STATUS,
                                                OFS_KEY};

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              typed;
    result_t           want;
  } dir_row_t;

  localparam result_t RES_QUIET = '0;
  localparam result_t RES_BAD   = '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0};

  localparam int DIR_ROWS = 36;
  localparam int LOCK_ROW = 30;

  // Rows from LOCK_ROW on set the lock, which only reset clears; play them after RANDOM_END.
  localparam dir_row_t DIR_STIM [DIR_ROWS] = '{
    '{OP_READ,  OFS_CTRL,   32'h0,         1'b1, RES_QUIET},
    '{OP_READ,  OFS_KEY,    32'h0,         1'b1, RES_QUIET},
    '{OP_READ,  8'hff,      32'h0,         1'b1, RES_BAD},
    '{OP_WRITE, 8'h0d,      32'hffff_ffff, 1'b1, RES_BAD},
    '{OP_WRITE, OFS_COUNT,  32'hffff_ffff, 1'b1, RES_BAD},
    '{OP_TICK,  8'h00,      32'h0,         1'b1, RES_QUIET},
    '{OP_NOP,   8'hff,      32'hffff_ffff, 1'b1, RES_QUIET},
    '{OP_WRITE, OFS_RELOAD, 32'hffff_ffff, 1'b1, RES_QUIET},
    '{OP_READ,  OFS_RELOAD, 32'h0,         1'b1, '{32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_WRITE, OFS_RELOAD, 32'h0,         1'b1, RES_QUIET},
    '{OP_WRITE, OFS_CTRL,   32'hffff_ffff, 1'b1, RES_QUIET},
    // zero reload fires on the first tick
    '{OP_TICK,  8'h00,      32'h0,         1'b1, '{32'h0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{OP_TICK,  8'h00,      32'h0,         1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{OP_READ,  OFS_STATUS, 32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_STATUS, 32'hffff_fffe, 1'b0, RES_QUIET},
    '{OP_WRITE, OFS_STATUS, 32'h1,         1'b1, RES_QUIET},
    '{OP_WRITE, OFS_RELOAD, 32'h2,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_KEY,    KEY_FEED,      1'b0, RES_QUIET},
    '{OP_TICK,  8'h00,      32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_KEY,    KEY_FEED ^ 1,  1'b0, RES_QUIET},
    '{OP_TICK,  8'h00,      32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_RELOAD, 32'hffff_ffff, 1'b0, RES_QUIET},
    '{OP_WRITE, OFS_CTRL,   32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_KEY,    KEY_FEED,      1'b0, RES_QUIET},
    '{OP_TICK,  8'h00,      32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_CTRL,   32'h5,         1'b0, RES_QUIET},
    '{OP_TICK,  8'h00,      32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_CTRL,   32'h0,         1'b0, RES_QUIET},
    '{OP_TICK,  8'h00,      32'h0,         1'b0, RES_QUIET},
    '{OP_READ,  OFS_COUNT,  32'h0,         1'b0, RES_QUIET},
    // lock, then try to move ctrl; the feed key must still work
    '{OP_WRITE, OFS_KEY,    KEY_LOCK,      1'b0, RES_QUIET},
    '{OP_READ,  OFS_CTRL,   32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_CTRL,   32'h7,         1'b0, RES_QUIET},
    '{OP_READ,  OFS_CTRL,   32'h0,         1'b0, RES_QUIET},
    '{OP_WRITE, OFS_KEY,    KEY_FEED,      1'b0, RES_QUIET},
    '{OP_READ,  OFS_COUNT,  32'h0,         1'b0, RES_QUIET}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_opcode;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_read_data;
  logic              out_bad_offset;
  logic              out_irq_level;
  logic              out_reset_pulse;
  logic              out_timeout_status;

  // predicted register file
  logic [CTL_W-1:0]  m_ctrl    = '0;
  logic [DATA_W-1:0] m_reload  = '0;
  logic [DATA_W-1:0] m_count   = '0;
  logic              m_timeout = 1'b0;
  logic              m_armed   = 1'b0;

  result_t     due_results[$];
  int unsigned accesses_sent  = 0;
  int unsigned responses_seen = 0;
  int unsigned fails          = 0;
  int unsigned offer_idle_pct = 20;
  int unsigned cycle_count    = 0;

  keyed_watchdog_timer_unit #(
    .COUNT_BITS(COUNT_BITS_DEF)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_bad_offset    (out_bad_offset),
    .out_irq_level     (out_irq_level),
    .out_reset_pulse   (out_reset_pulse),
    .out_timeout_status(out_timeout_status)
  );

  always #5 clk = ~clk;

  // Apply one access to the predicted registers and return the response it gives.
  function automatic result_t watchdog_step(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data);
    result_t          r;
    logic [CTL_W-1:0] nxt;
    r = '0;
    case (op)
      OP_TICK: begin
        if (m_armed && m_ctrl[CTL_EN]) begin
          if (m_count > 1) begin
            m_count = (m_count - 1) & CNT_MASK;
          end else begin
            m_count = '0;
            m_timeout = 1'b1;
            m_armed = 1'b0;
            r.reset_pulse = m_ctrl[CTL_RSTEN];
          end
        end
      end
      OP_READ: begin
        case (addr)
          OFS_CTRL:   r.read_data = DATA_W'(m_ctrl);
          OFS_RELOAD: r.read_data = m_reload;
          OFS_COUNT:  r.read_data = m_count;
          OFS_STATUS: r.read_data = DATA_W'(m_timeout);
          OFS_KEY:    r.read_data = '0;
          default:    r.bad_offset = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (addr)
          OFS_CTRL: begin
            if (!m_ctrl[CTL_LOCK]) begin
              nxt = m_ctrl;
              nxt[CTL_EN] = data[CTL_EN];
              nxt[CTL_IRQEN] = data[CTL_IRQEN];
              nxt[CTL_RSTEN] = data[CTL_RSTEN];
              // enable rising reloads and arms; falling disarms and holds the count
              if (data[CTL_EN] && !m_ctrl[CTL_EN]) begin
                m_count = m_reload;
                m_armed = 1'b1;
              end else if (!data[CTL_EN] && m_ctrl[CTL_EN]) begin
                m_armed = 1'b0;
              end
              m_ctrl = nxt;
            end
          end
          OFS_RELOAD: m_reload = data & CNT_MASK;
          OFS_STATUS: begin
            if (data[0]) m_timeout = 1'b0;
          end
          OFS_KEY: begin
            if (data == KEY_FEED) begin
              m_count = m_reload;
              m_armed = m_ctrl[CTL_EN];
            end else if (data == KEY_LOCK) begin
              m_ctrl[CTL_LOCK] = 1'b1;
            end
          end
          default: r.bad_offset = 1'b1;
        endcase
      end
      default: ;
    endcase
    r.timeout_status = m_timeout;
    r.irq_level = m_timeout & m_ctrl[CTL_IRQEN];
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one access, hold it until the transfer, record the response it must give.
  task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input logic typed,
                           input result_t want);
    result_t r;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = watchdog_step(op, addr, data);
    due_results.push_back(typed ? want : r);
    accesses_sent++;
    if (accesses_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       offer_idle_pct = 0;
        1:       offer_idle_pct = 20;
        default: offer_idle_pct = 60;
      endcase
    end
    if ($urandom_range(1, 100) <= offer_idle_pct) begin
      in_valid <= 1'b0;
      repeat (idle_cycles()) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted response has come back.
  task automatic drain_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // One watchdog session: program reload and ctrl, then mostly ticks with reads,
  // feeds, status clears, ctrl and reload changes and some raw noise mixed in.
  task automatic run_session();
    logic [DATA_W-1:0] data;
    int unsigned       steps;
    int unsigned       pick;
    data = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 12));
    send_item(OP_WRITE, OFS_RELOAD, data, 1'b0, RES_QUIET);
    data = $urandom;
    data[CTL_EN] = ($urandom_range(0, 7) != 0);
    send_item(OP_WRITE, OFS_CTRL, data, 1'b0, RES_QUIET);
    steps = $urandom_range(4, 30);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(OP_TICK, ADDR_W'($urandom_range(0, 255)), $urandom, 1'b0, RES_QUIET);
      end else if (pick < 70) begin
        send_item(OP_READ, REG_OFS[$urandom_range(0, 4)], $urandom, 1'b0, RES_QUIET);
      end else if (pick < 78) begin
        send_item(OP_WRITE, OFS_KEY, KEY_FEED, 1'b0, RES_QUIET);
      end else if (pick < 84) begin
        send_item(OP_WRITE, OFS_STATUS, $urandom, 1'b0, RES_QUIET);
      end else if (pick < 88) begin
        send_item(OP_WRITE, OFS_CTRL, $urandom, 1'b0, RES_QUIET);
      end else if (pick < 91) begin
        send_item(OP_WRITE, OFS_RELOAD, $urandom_range(0, 12), 1'b0, RES_QUIET);
      end else begin
        send_item(2'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 255)), $urandom,
                  1'b0, RES_QUIET);
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                           input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
      fails++;
    end
  endtask

  initial begin : stimulus
    in_valid = 1'b0;
    in_opcode = '0;
    in_address = '0;
    in_write_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < LOCK_ROW; i++) begin
      send_item(DIR_STIM[i].op, DIR_STIM[i].addr, DIR_STIM[i].data, DIR_STIM[i].typed,
                DIR_STIM[i].want);
    end
    while (accesses_sent < PAUSE_AT) run_session();
    drain_responses();
    while (accesses_sent < RANDOM_END) run_session();
    for (int i = LOCK_ROW; i < DIR_ROWS; i++) begin
      send_item(DIR_STIM[i].op, DIR_STIM[i].addr, DIR_STIM[i].data, DIR_STIM[i].typed,
                DIR_STIM[i].want);
    end
    while (accesses_sent < ITEM_TOTAL) run_session();
    drain_responses();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver pacing: random stall runs, plus two long hold-offs that back the
  // block up into its input while the sender keeps offering.
  initial begin : response_pacing
    int unsigned holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds_done < 2 &&
          responses_seen >= (holds_done == 0 ? HOLD_FIRST : HOLD_SECOND)) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        repeat (idle_cycles()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      responses_seen++;
      if (due_results.size() == 0) begin
        $error("response transfer with nothing outstanding");
        fails++;
      end else begin
        want = due_results.pop_front();
        cmp_field("read_data", want.read_data, out_read_data);
        cmp_field("bad_offset", DATA_W'(want.bad_offset), DATA_W'(out_bad_offset));
        cmp_field("irq_level", DATA_W'(want.irq_level), DATA_W'(out_irq_level));
        cmp_field("reset_pulse", DATA_W'(want.reset_pulse), DATA_W'(out_reset_pulse));
        cmp_field("timeout_status", DATA_W'(want.timeout_status),
                  DATA_W'(out_timeout_status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
